// ===== src/blha_pkg.sv =====
// ----------------------------------------------------------------------------
// Bus lease handshake arbiter package
// Mode encoding, response codes, command codes and the result record.
// ----------------------------------------------------------------------------
package blha_pkg;

  // lease mode, one-hot
  typedef enum logic [2:0] {
    MODE_FATAL  = 3'b001,
    MODE_ACTIVE = 3'b010,
    MODE_PAUSED = 3'b100
  } mode_t;

  // item kind carried on in_tuser
  localparam logic OP_BOOT    = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  // request commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_CANCEL  = 2'd3;

  // response states
  localparam logic [2:0] RS_RESET    = 3'd0;
  localparam logic [2:0] RS_FATAL    = 3'd1;
  localparam logic [2:0] RS_ACTIVE   = 3'd2;
  localparam logic [2:0] RS_REJECTED = 3'd3;
  localparam logic [2:0] RS_QUIESCED = 3'd4;

  // response errors
  localparam logic [1:0] ER_NONE      = 2'd0;
  localparam logic [1:0] ER_BOOT_BUSY = 2'd1;
  localparam logic [1:0] ER_RETAKE    = 2'd2;
  localparam logic [1:0] ER_TIMEOUT   = 2'd3;

  localparam int RESP_EPOCH_W = 32;
  localparam int COUNT_W      = 32;

  // one result item
  typedef struct packed {
    logic                    transfer_allowed;
    logic [COUNT_W-1:0]      transition_total;
    logic [RESP_EPOCH_W-1:0] resp_epoch;
    logic                    resp_restored;
    logic [1:0]              resp_error;
    logic [2:0]              resp_state;
    logic                    published;
    logic                    service_return;
  } res_t;

endpackage

// ===== src/blha_core.sv =====
// ----------------------------------------------------------------------------
// Bus lease handshake arbiter step logic
// Combinational next-state and result for one boot or service item.
// ----------------------------------------------------------------------------
module blha_core #(
  parameter int EPOCH_BITS = 32
) (
  input  logic                            opcode,
  input  logic                            take_ok,
  input  logic                            owns_sem,
  input  logic                            header_valid,
  input  logic [31:0]                     req_epoch,
  input  logic [1:0]                      command,
  input  logic                            quiesce_ok,
  input  blha_pkg::mode_t                 mode,
  input  logic [EPOCH_BITS-1:0]           cur_epoch,
  input  logic [blha_pkg::COUNT_W-1:0]    trans_cnt,
  input  logic [EPOCH_BITS-1:0]           last_epoch,
  input  logic [2:0]                      last_state,
  input  logic                            last_restored,
  output blha_pkg::mode_t                 mode_nxt,
  output logic [EPOCH_BITS-1:0]           cur_epoch_nxt,
  output logic [blha_pkg::COUNT_W-1:0]    trans_cnt_nxt,
  output logic [EPOCH_BITS-1:0]           last_epoch_nxt,
  output logic [2:0]                      last_state_nxt,
  output logic                            last_restored_nxt,
  output blha_pkg::res_t                  res
);

  logic [EPOCH_BITS-1:0] ep;
  logic [31:0]           resp_ep;
  logic                  pub;
  logic [1:0]            err;
  logic                  ret;
  logic                  owned_now;

  // epochs are kept to EPOCH_BITS and reported in 32 bits
  generate
    if (EPOCH_BITS > 32) begin : g_wide
      assign ep      = {{(EPOCH_BITS-32){1'b0}}, req_epoch};
      assign resp_ep = last_epoch_nxt[31:0];
    end else if (EPOCH_BITS == 32) begin : g_same
      assign ep      = req_epoch;
      assign resp_ep = last_epoch_nxt;
    end else begin : g_narrow
      assign ep      = req_epoch[EPOCH_BITS-1:0];
      assign resp_ep = {{(32-EPOCH_BITS){1'b0}}, last_epoch_nxt};
    end
  endgenerate

  always_comb begin
    mode_nxt          = mode;
    cur_epoch_nxt     = cur_epoch;
    trans_cnt_nxt     = trans_cnt;
    last_epoch_nxt    = last_epoch;
    last_state_nxt    = last_state;
    last_restored_nxt = last_restored;
    pub               = 1'b0;
    err               = blha_pkg::ER_NONE;
    ret               = 1'b0;
    owned_now         = owns_sem;

    if (opcode == blha_pkg::OP_BOOT) begin
      cur_epoch_nxt     = '0;
      trans_cnt_nxt     = '0;
      last_epoch_nxt    = '0;
      last_restored_nxt = 1'b0;
      pub               = 1'b1;
      owned_now         = take_ok;
      if (take_ok) begin
        mode_nxt       = blha_pkg::MODE_ACTIVE;
        last_state_nxt = blha_pkg::RS_ACTIVE;
        ret            = 1'b1;
      end else begin
        mode_nxt       = blha_pkg::MODE_FATAL;
        last_state_nxt = blha_pkg::RS_FATAL;
        err            = blha_pkg::ER_BOOT_BUSY;
      end
    end else begin
      case (mode)
        blha_pkg::MODE_ACTIVE: begin
          if (!owns_sem) begin
            // lost the semaphore under us
            mode_nxt          = blha_pkg::MODE_FATAL;
            trans_cnt_nxt     = trans_cnt + 1'b1;
            pub               = 1'b1;
            err               = blha_pkg::ER_RETAKE;
            last_epoch_nxt    = cur_epoch;
            last_state_nxt    = blha_pkg::RS_FATAL;
            last_restored_nxt = 1'b0;
          end else if (!header_valid) begin
            ret = 1'b1;
          end else if (command == blha_pkg::CMD_CANCEL && ep != '0) begin
            ret = 1'b1;
            // repeated cancel of the same epoch publishes nothing
            if (cur_epoch != ep || last_epoch != ep ||
                last_state != blha_pkg::RS_ACTIVE || !last_restored) begin
              cur_epoch_nxt     = ep;
              trans_cnt_nxt     = trans_cnt + 1'b1;
              pub               = 1'b1;
              last_epoch_nxt    = ep;
              last_state_nxt    = blha_pkg::RS_ACTIVE;
              last_restored_nxt = 1'b1;
            end
          end else if (command == blha_pkg::CMD_ACQUIRE && ep != '0 &&
                       ep != cur_epoch) begin
            cur_epoch_nxt     = ep;
            trans_cnt_nxt     = trans_cnt + 1'b1;
            pub               = 1'b1;
            last_epoch_nxt    = ep;
            last_restored_nxt = 1'b0;
            if (!quiesce_ok) begin
              last_state_nxt = blha_pkg::RS_REJECTED;
              err            = blha_pkg::ER_TIMEOUT;
              ret            = 1'b1;
            end else begin
              mode_nxt       = blha_pkg::MODE_PAUSED;
              last_state_nxt = blha_pkg::RS_QUIESCED;
            end
          end else begin
            ret = 1'b1;
          end
        end
        blha_pkg::MODE_PAUSED: begin
          if (header_valid && ep == cur_epoch && take_ok &&
              (command == blha_pkg::CMD_RELEASE ||
               command == blha_pkg::CMD_CANCEL)) begin
            mode_nxt          = blha_pkg::MODE_ACTIVE;
            trans_cnt_nxt     = trans_cnt + 1'b1;
            pub               = 1'b1;
            last_epoch_nxt    = ep;
            last_state_nxt    = blha_pkg::RS_ACTIVE;
            last_restored_nxt = 1'b1;
            owned_now         = 1'b1;
            ret               = 1'b1;
          end
        end
        default: begin
          // fatal: service items change nothing
        end
      endcase
    end
  end

  always_comb begin
    res.service_return   = ret;
    res.published        = pub;
    res.resp_state       = last_state_nxt;
    res.resp_error       = err;
    res.resp_restored    = last_restored_nxt;
    res.resp_epoch       = resp_ep;
    res.transition_total = trans_cnt_nxt;
    res.transfer_allowed = (mode_nxt == blha_pkg::MODE_ACTIVE) && owned_now;
  end

endmodule

// ===== src/bus_lease_handshake_arbiter.sv =====
// ----------------------------------------------------------------------------
// Bus lease handshake arbiter
// Result: registered in the output register in the cycle after the input
//   transfer. Throughput: one item per cycle unless out_tready stalls a held
//   result; the next item is taken while a result is being taken, set by the single output register.
// Reset (rst_n low, synchronous): mode fatal, epochs, counter and last
//   response cleared, output register empty.
// ----------------------------------------------------------------------------
module bus_lease_handshake_arbiter #(
  parameter int EPOCH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] take_ok, [1] owns_sem, [2] header_valid, [34:3] req_epoch,
  // [36:35] command, [37] quiesce_ok, [39:38] zero
  input  logic [39:0] in_tdata,
  // [0] opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] service_return, [1] published, [4:2] resp_state, [6:5] resp_error,
  // [7] resp_restored, [39:8] resp_epoch, [71:40] transition_total,
  // [72] transfer_allowed, [79:73] zero
  output logic [79:0] out_tdata
);

  blha_pkg::mode_t                mode_r, mode_nxt;
  logic [EPOCH_BITS-1:0]          cur_epoch_r, cur_epoch_nxt;
  logic [blha_pkg::COUNT_W-1:0]   trans_cnt_r, trans_cnt_nxt;
  logic [EPOCH_BITS-1:0]          last_epoch_r, last_epoch_nxt;
  logic [2:0]                     last_state_r, last_state_nxt;
  logic                           last_restored_r, last_restored_nxt;
  blha_pkg::res_t                 res_nxt, res_r;
  logic                           out_valid_r;
  logic                           in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  blha_core #(
    .EPOCH_BITS(EPOCH_BITS)
  ) u_core (
    .opcode           (in_tuser),
    .take_ok          (in_tdata[0]),
    .owns_sem         (in_tdata[1]),
    .header_valid     (in_tdata[2]),
    .req_epoch        (in_tdata[34:3]),
    .command          (in_tdata[36:35]),
    .quiesce_ok       (in_tdata[37]),
    .mode             (mode_r),
    .cur_epoch        (cur_epoch_r),
    .trans_cnt        (trans_cnt_r),
    .last_epoch       (last_epoch_r),
    .last_state       (last_state_r),
    .last_restored    (last_restored_r),
    .mode_nxt         (mode_nxt),
    .cur_epoch_nxt    (cur_epoch_nxt),
    .trans_cnt_nxt    (trans_cnt_nxt),
    .last_epoch_nxt   (last_epoch_nxt),
    .last_state_nxt   (last_state_nxt),
    .last_restored_nxt(last_restored_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= blha_pkg::MODE_FATAL;
      cur_epoch_r     <= '0;
      trans_cnt_r     <= '0;
      last_epoch_r    <= '0;
      last_state_r    <= blha_pkg::RS_RESET;
      last_restored_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_r          <= mode_nxt;
        cur_epoch_r     <= cur_epoch_nxt;
        trans_cnt_r     <= trans_cnt_nxt;
        last_epoch_r    <= last_epoch_nxt;
        last_state_r    <= last_state_nxt;
        last_restored_r <= last_restored_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_tready) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, res_r};

  // counter moves by at most one per service item
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == blha_pkg::OP_SERVICE |=>
      trans_cnt_r == $past(trans_cnt_r) || trans_cnt_r == $past(trans_cnt_r) + 1'b1)
    else $error("transition counter jumped");

  // boot clears the counter
  a_boot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == blha_pkg::OP_BOOT |=> trans_cnt_r == '0)
    else $error("boot did not clear the counter");

  // state holds without an input transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(mode_r) && $stable(trans_cnt_r) && $stable(cur_epoch_r))
    else $error("state changed without a transfer");

  // a pending result that allows transfers matches the active mode
  a_allow_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.transfer_allowed |-> mode_r == blha_pkg::MODE_ACTIVE)
    else $error("transfer allowed outside active mode");

  // nothing published means no error code
  a_err_pub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.published |-> res_r.resp_error == blha_pkg::ER_NONE)
    else $error("error reported without a publish");

endmodule
